// ===== rtl/etrr_pkg.sv =====
// package: shared types and constants for the task scheduler
package etrr_pkg;
    localparam int MaxTasksDef    = 32;
    localparam int TimeoutBitsDef = 16;
    localparam int PendMax        = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_WAIT  = 3'd0,
        OP_TICK  = 3'd1,
        OP_ASYNC = 3'd2,
        OP_SYNC  = 3'd3,
        OP_STOP  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_EVPASS,
        S_SEARCH,
        S_FETCH,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic park;
        logic pass_start;
        logic pass_step;
        logic use_pend;
        logic do_ticks;
        logic do_events;
        logic do_stop;
        logic tick_inc;
        logic async_or;
        logic srch_start;
        logic srch_step;
        logic fetch;
        logic set_idle;
    } t_cmd;

    typedef struct packed {
        logic pass_last;
        logic srch_done;
        logic have_ticks;
        logic have_events;
    } t_sts;
endpackage

// ===== rtl/etrr_ctrl.sv =====
// controller: sequences passes over task entries and the round-robin search
module etrr_ctrl
    import etrr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_op,
    input  logic       i_to_nz,
    input  logic       i_out_taken,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic       o_busy,
    output logic       o_out_valid
);
    t_state r_state, n_state;
    logic   r_tick_phase, n_tick_phase;
    logic   r_wait, n_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tick_phase <= 1'b0;
            r_wait       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_tick_phase <= n_tick_phase;
            r_wait       <= n_wait;
        end
    end

    always_comb begin
        o_cmd        = '0;
        n_state      = r_state;
        n_tick_phase = r_tick_phase;
        n_wait       = r_wait;
        o_busy       = (r_state != S_IDLE);
        o_out_valid  = (r_state == S_OUT);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_wait     = 1'b0;
                    unique case (i_op)
                        OP_WAIT: begin
                            o_cmd.park = i_to_nz;
                            n_wait     = 1'b1;
                            if (i_sts.have_ticks) begin
                                o_cmd.pass_start = 1'b1;
                                n_tick_phase     = 1'b1;
                                n_state          = S_PASS;
                            end else if (i_sts.have_events) begin
                                o_cmd.pass_start = 1'b1;
                                n_tick_phase     = 1'b0;
                                n_state          = S_EVPASS;
                            end else begin
                                o_cmd.srch_start = 1'b1;
                                n_state          = S_SEARCH;
                            end
                        end
                        OP_TICK: begin
                            o_cmd.tick_inc = 1'b1;
                            n_state        = S_FETCH;
                        end
                        OP_ASYNC: begin
                            o_cmd.async_or = 1'b1;
                            n_state        = S_FETCH;
                        end
                        OP_SYNC, OP_STOP: begin
                            o_cmd.pass_start = 1'b1;
                            n_state          = S_PASS;
                            n_tick_phase     = 1'b0;
                        end
                        default: n_state = S_FETCH;
                    endcase
                end
            end
            S_PASS: begin
                o_cmd.pass_step = 1'b1;
                o_cmd.do_ticks  = r_tick_phase;
                o_cmd.do_events = !r_tick_phase && (i_op == OP_SYNC);
                o_cmd.do_stop   = !r_tick_phase && (i_op == OP_STOP);
                if (i_sts.pass_last) begin
                    if (!r_wait) begin
                        n_state = S_FETCH;
                    end else if (i_sts.have_events) begin
                        o_cmd.pass_start = 1'b1;
                        n_tick_phase     = 1'b0;
                        n_state          = S_EVPASS;
                    end else begin
                        o_cmd.srch_start = 1'b1;
                        n_state          = S_SEARCH;
                    end
                end
            end
            S_EVPASS: begin
                o_cmd.pass_step = 1'b1;
                o_cmd.do_events = 1'b1;
                o_cmd.use_pend  = 1'b1;
                if (i_sts.pass_last) begin
                    o_cmd.srch_start = 1'b1;
                    n_state          = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.srch_step = 1'b1;
                if (i_sts.srch_done) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                o_cmd.fetch    = 1'b1;
                o_cmd.set_idle = r_wait;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_out_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== rtl/etrr_dp.sv =====
// datapath: task tables, pending state, per-entry pass and round-robin search
module etrr_dp
    import etrr_pkg::*;
#(
    parameter int MAX_TASKS    = MaxTasksDef,
    parameter int TIMEOUT_BITS = TimeoutBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_num,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_event_mask,
    input  logic [15:0] i_timeout,
    input  logic [31:0] i_task_mask,
    output t_sts        o_sts,
    output logic [4:0]  o_current_task,
    output logic [31:0] o_remaining_wait,
    output logic [31:0] o_tick_count,
    output logic        o_idle
);
    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = ((TIMEOUT_BITS > 16) ? TIMEOUT_BITS : 16) + 1;

    logic [5:0]              r_num;
    logic [MAX_TASKS-1:0]    r_ready, n_ready;
    logic [IW-1:0]           r_run;
    logic [15:0]             r_pticks;
    logic [31:0]             r_pev;
    logic [31:0]             r_total;
    logic [31:0]             r_ev;
    logic [MAX_TASKS-1:0]    r_tm;
    logic [IW-1:0]           r_idx;
    logic [CW-1:0]           r_cnt;
    logic [IW-1:0]           r_sidx;
    logic                    r_found;
    logic                    r_idle;
    logic [31:0]             r_wait_out;
    logic [31:0]             r_wmem [MAX_TASKS];
    logic [TIMEOUT_BITS-1:0] r_xmem [MAX_TASKS];

    logic [CW-1:0]           w_n;
    logic [31:0]             w_ev;
    logic [31:0]             w_wm;
    logic [TIMEOUT_BITS-1:0] w_xc;
    logic [TW-1:0]           w_t;
    logic [IW-1:0]           w_start;

    always_comb begin
        if (r_num == 6'd0) begin
            w_n = CW'(1);
        end else if (r_num > 6'(MAX_TASKS)) begin
            w_n = CW'(MAX_TASKS);
        end else begin
            w_n = CW'(r_num);
        end
    end

    assign w_ev     = i_cmd.use_pend ? r_pev : r_ev;
    assign w_wm     = r_wmem[r_idx];
    assign w_xc     = r_xmem[r_idx];
    assign w_t      = TW'(r_pticks);
    assign w_start  = (CW'(r_run) + CW'(1) >= w_n) ? '0 : IW'(r_run + IW'(1));

    assign o_sts.pass_last   = (r_cnt == w_n - CW'(1));
    assign o_sts.srch_done   = r_found || (r_cnt == w_n);
    assign o_sts.have_ticks  = (r_pticks != 16'd0);
    assign o_sts.have_events = (r_pev != 32'd0);

    always_comb begin
        n_ready = r_ready;
        if (i_cmd.park) begin
            n_ready[r_run] = 1'b0;
        end
        if (i_cmd.do_ticks && (w_xc != '0) && (TW'(w_xc) <= w_t)) begin
            n_ready[r_idx] = 1'b1;
        end
        if (i_cmd.do_events && ((w_wm & w_ev) != 32'd0)) begin
            n_ready[r_idx] = 1'b1;
        end
        if (i_cmd.do_stop && r_cnt == '0) begin
            n_ready = n_ready & ~(r_tm & ~(MAX_TASKS'(1) << r_run));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_wmem[i] <= 32'd0;
                r_xmem[i] <= '0;
            end
            r_ev       <= 32'd0;
            r_tm       <= '0;
            r_wait_out <= 32'd0;
        end else begin
            if (i_cmd.load) begin
                r_ev <= i_event_mask;
                r_tm <= i_task_mask[MAX_TASKS-1:0];
            end
            if (i_cmd.park) begin
                r_wmem[r_run] <= i_event_mask;
                r_xmem[r_run] <= TIMEOUT_BITS'(i_timeout);
            end
            if (i_cmd.do_ticks && (w_xc != '0)) begin
                if (TW'(w_xc) <= w_t) begin
                    r_xmem[r_idx] <= '0;
                end else begin
                    r_xmem[r_idx] <= TIMEOUT_BITS'(TW'(w_xc) - w_t);
                end
            end
            if (i_cmd.do_events && ((w_wm & w_ev) != 32'd0)) begin
                r_wmem[r_idx] <= w_wm & ~w_ev;
            end
            if (i_cmd.do_stop && r_tm[r_idx] && (r_idx != r_run)) begin
                r_wmem[r_idx] <= 32'd0;
                r_xmem[r_idx] <= '0;
            end
            if (i_cmd.fetch) begin
                r_wait_out <= r_wmem[r_run];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num    <= 6'd1;
            r_ready  <= '1;
            r_run    <= '0;
            r_pticks <= 16'd0;
            r_pev    <= 32'd0;
            r_total  <= 32'd0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_sidx   <= '0;
            r_found  <= 1'b0;
            r_idle   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num <= i_cfg_num;
            end
            r_ready <= n_ready;
            if (i_cmd.load) begin
                r_idle <= 1'b0;
            end
            if (i_cmd.tick_inc && (r_pticks != 16'(PendMax))) begin
                r_pticks <= r_pticks + 16'd1;
            end
            if (i_cmd.async_or) begin
                r_pev <= r_pev | i_event_mask;
            end
            if (i_cmd.pass_start) begin
                r_idx <= '0;
            end else if (i_cmd.pass_step) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.pass_start || i_cmd.srch_start) begin
                r_cnt <= '0;
            end else if (i_cmd.pass_step || (i_cmd.srch_step && !o_sts.srch_done)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.pass_step) begin
                if (o_sts.pass_last && i_cmd.do_ticks) begin
                    r_pticks <= 16'd0;
                    r_total  <= r_total + 32'(r_pticks);
                end
                if (o_sts.pass_last && i_cmd.use_pend) begin
                    r_pev <= 32'd0;
                end
            end
            if (i_cmd.srch_start) begin
                r_sidx  <= w_start;
                r_found <= 1'b0;
            end
            if (i_cmd.srch_step && !o_sts.srch_done) begin
                if (r_ready[r_sidx]) begin
                    r_run   <= r_sidx;
                    r_found <= 1'b1;
                end
                r_sidx <= (CW'(r_sidx) + CW'(1) >= w_n) ? '0 : r_sidx + IW'(1);
            end
            if (i_cmd.set_idle) begin
                r_idle <= !r_found;
            end
        end
    end

    assign o_current_task   = 5'(r_run);
    assign o_remaining_wait = r_wait_out;
    assign o_tick_count     = r_total;
    assign o_idle           = r_idle;

    a_found_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch && i_cmd.set_idle && r_found |-> CW'(r_run) < w_n)
        else $error("selected task beyond count");
    a_pticks_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fetch && i_cmd.set_idle && r_found |-> r_pticks == 16'd0)
        else $error("pending ticks left after schedule");
    a_found_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.srch_step && !o_sts.srch_done && r_ready[r_sidx] |=> r_found)
        else $error("ready task missed");
endmodule

// ===== rtl/event_timeout_round_robin_scheduler_core.sv =====
// top level: round-robin task scheduler with event wait and timeouts
// tick, async and unknown words go straight to the result; sync and stop first make one pass over the tasks
// wait: tick pass and event pass when pending, then a search over up to n tasks (n = task count)
// one word at a time; next word accepted once the result is taken
// synchronous active-low reset: all tasks ready, task 0 running, tables zero
module event_timeout_round_robin_scheduler_core
    import etrr_pkg::*;
#(
    parameter int MAX_TASKS    = MaxTasksDef,
    parameter int TIMEOUT_BITS = TimeoutBitsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [5:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // event_mask[31:0], timeout[47:32], task_mask[79:48]
    input  logic [79:0]  s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // current_task[4:0], remaining_wait[36:5], tick_count[68:37]
    output logic [71:0]  m_axis_tdata,
    // idle[0]
    output logic         m_axis_tuser
);
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_busy;
    logic        w_start;
    logic [4:0]  w_cur;
    logic [31:0] w_rem;
    logic [31:0] w_tick;
    logic        w_idle;
    logic [2:0]  r_op;

    assign s_axis_tready = !w_busy;
    assign w_start       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_op <= s_axis_tuser;
        end
    end

    etrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_op        (w_start ? s_axis_tuser : r_op),
        .i_to_nz     (TIMEOUT_BITS'(s_axis_tdata[47:32]) != '0),
        .i_out_taken (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_busy      (w_busy),
        .o_out_valid (m_axis_tvalid)
    );

    etrr_dp #(
        .MAX_TASKS    (MAX_TASKS),
        .TIMEOUT_BITS (TIMEOUT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_num        (i_cfg_wdata),
        .i_cmd            (w_cmd),
        .i_event_mask     (s_axis_tdata[31:0]),
        .i_timeout        (s_axis_tdata[47:32]),
        .i_task_mask      (s_axis_tdata[79:48]),
        .o_sts            (w_sts),
        .o_current_task   (w_cur),
        .o_remaining_wait (w_rem),
        .o_tick_count     (w_tick),
        .o_idle           (w_idle)
    );

    assign m_axis_tdata = {3'b000, w_tick, w_rem, w_cur};
    assign m_axis_tuser = w_idle;
endmodule

// ===== tb/etrr_checker.sv =====
// checker: predicts scheduler results and compares them with the output words
`timescale 1ns / 100ps
module etrr_checker
    import etrr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [79:0] i_in_data,
    input  logic [2:0]  i_in_user,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [71:0] i_out_data,
    input  logic        i_out_user,
    output int          o_fail_count,
    output int          o_pending
);
    logic [5:0]  cnt_reg;
    logic [31:0] ready_bits;
    logic [4:0]  run_task;
    logic [31:0] wmask [32];
    logic [15:0] expire [32];
    logic [15:0] pend_ticks;
    logic [31:0] pend_events;
    logic [31:0] ticks_total;
    logic [69:0] sched_q [$];

    function automatic int active_tasks();
        if (cnt_reg == 0) return 1;
        if (cnt_reg > 32) return 32;
        return int'(cnt_reg);
    endfunction

    task automatic wake_tasks(input logic [31:0] ev);
        int n;
        n = active_tasks();
        for (int i = 0; i < n; i++)
            if ((wmask[i] & ev) != 0) begin
                ready_bits[i] = 1'b1;
                wmask[i] &= ~ev;
            end
    endtask

    task automatic predict_word(input logic [2:0] u, input logic [79:0] d);
        t_op         op;
        logic [31:0] ev, tm;
        logic [15:0] to;
        logic        idle_flag, found;
        int          n, start, idx;
        op = t_op'(u);
        ev = d[31:0];
        to = d[47:32];
        tm = d[79:48];
        idle_flag = 1'b0;
        n = active_tasks();
        case (op)
            OP_WAIT: begin
                if (to != 0) begin
                    ready_bits[run_task] = 1'b0;
                    expire[run_task] = to;
                    wmask[run_task] = ev;
                end
                if (pend_ticks != 0) begin
                    ticks_total += pend_ticks;
                    for (int i = 0; i < n; i++)
                        if (expire[i] != 0) begin
                            if (expire[i] <= pend_ticks) begin
                                expire[i] = 0;
                                ready_bits[i] = 1'b1;
                            end else begin
                                expire[i] -= pend_ticks;
                            end
                        end
                    pend_ticks = 0;
                end
                if (pend_events != 0) begin
                    wake_tasks(pend_events);
                    pend_events = 0;
                end
                start = int'(run_task) + 1;
                if (start >= n) start = 0;
                found = 1'b0;
                for (int k = 0; k < n && !found; k++) begin
                    idx = start + k;
                    if (idx >= n) idx -= n;
                    if (ready_bits[idx]) begin
                        run_task = idx[4:0];
                        found = 1'b1;
                    end
                end
                idle_flag = !found;
            end
            OP_TICK: if (pend_ticks != 16'hFFFF) pend_ticks++;
            OP_ASYNC: pend_events |= ev;
            OP_SYNC: wake_tasks(ev);
            OP_STOP: begin
                tm[run_task] = 1'b0;
                ready_bits &= ~tm;
                for (int i = 0; i < n; i++)
                    if (tm[i]) begin
                        wmask[i] = 0;
                        expire[i] = 0;
                    end
            end
            default: ;
        endcase
        sched_q.push_back({idle_flag, ticks_total, wmask[run_task], run_task});
    endtask

    always @(posedge i_clk) begin
        logic [69:0] exp_word;
        logic [69:0] act_word;
        if (!i_rst_n) begin
            cnt_reg = 6'd1;
            ready_bits = '1;
            run_task = '0;
            for (int i = 0; i < 32; i++) begin
                wmask[i] = '0;
                expire[i] = '0;
            end
            pend_ticks = '0;
            pend_events = '0;
            ticks_total = '0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) cnt_reg = i_cfg_wdata;
            if (i_in_valid && i_in_ready) predict_word(i_in_user, i_in_data);
            if (i_out_valid && i_out_ready) begin
                act_word = {i_out_user, i_out_data[68:0]};
                if (sched_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output word %h", act_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_word = sched_q.pop_front();
                    if (act_word !== exp_word) begin
                        if (o_fail_count < 10)
                            $display("mismatch: task %0d/%0d wait %h/%h ticks %h/%h idle %b/%b",
                                exp_word[4:0], act_word[4:0], exp_word[36:5],
                                act_word[36:5], exp_word[68:37], act_word[68:37],
                                exp_word[69], act_word[69]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= sched_q.size();
    end
endmodule

// ===== tb/tb_event_timeout_round_robin_scheduler_core.sv =====
// testbench top: stimulus, stalls and verdict for the task scheduler
`timescale 1ns / 100ps
module tb_event_timeout_round_robin_scheduler_core
    import etrr_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tuser;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    bit          calm_phase;
    bit          hold_off;
    bit          started;

    event_timeout_round_robin_scheduler_core dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
    );

    etrr_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready), .i_in_data(s_axis_tdata),
        .i_in_user(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_user(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, calm stretch, one long hold-off
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            m_axis_tready <= calm_phase || ($urandom_range(99) >= 33);
        end
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if (!started || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000) begin
            $display("event_timeout_round_robin_scheduler_core regression: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [2:0] op, input logic [31:0] ev,
                             input logic [15:0] to, input logic [31:0] tm);
        while (!calm_phase && $urandom_range(99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {tm, to, ev};
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_and_config(input logic [5:0] n);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_word();
        logic [2:0]  op;
        logic [31:0] ev;
        logic [15:0] to;
        int          r;
        r = $urandom_range(99);
        if (r < 40) op = OP_WAIT;
        else if (r < 60) op = OP_TICK;
        else if (r < 72) op = OP_ASYNC;
        else if (r < 84) op = OP_SYNC;
        else if (r < 95) op = OP_STOP;
        else op = 3'($urandom_range(7, 5));
        ev = ($urandom_range(3) == 0) ? $urandom : (32'd1 << $urandom_range(31));
        r = $urandom_range(9);
        to = (r < 3) ? 16'd0 : (r < 8) ? 16'($urandom_range(1, 4)) : 16'($urandom);
        send_word(op, ev, to, ($urandom_range(3) == 0) ? $urandom : $urandom & $urandom);
    endtask

    initial begin
        logic [5:0] cfg_list [8] = '{6'd4, 6'd0, 6'd32, 6'd63, 6'd2, 6'd17, 6'd33, 6'd8};
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        calm_phase = 1'b0;
        hold_off = 1'b0;
        started = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        started = 1'b1;
        @(posedge i_clk);
        // directed: default task count, then four tasks
        send_word(OP_WAIT, 32'hFFFF_FFFF, 16'hFFFF, 32'h0);
        send_word(OP_WAIT, 32'h0, 16'h0, 32'h0);
        drain_and_config(6'd4);
        send_word(OP_WAIT, 32'h0000_0001, 16'd2, 32'h0);
        send_word(OP_WAIT, 32'h8000_0000, 16'd1, 32'h0);
        send_word(OP_TICK, 32'h0, 16'h0, 32'h0);
        send_word(OP_ASYNC, 32'h8000_0000, 16'h0, 32'h0);
        send_word(OP_WAIT, 32'h0, 16'h0, 32'h0);
        send_word(OP_SYNC, 32'hFFFF_FFFF, 16'h0, 32'h0);
        send_word(OP_STOP, 32'h0, 16'h0, 32'hFFFF_FFFF);
        send_word(OP_WAIT, 32'h0, 16'h0, 32'h0);
        send_word(OP_WAIT, 32'h1, 16'd1, 32'h0);
        send_word(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(3'd7, 32'h0, 16'h0, 32'h0);
        send_word(OP_STOP, 32'h0, 16'h0, 32'h0);
        send_word(OP_SYNC, 32'h0, 16'h0, 32'h0);
        // shrink the count below the running task
        drain_and_config(6'd2);
        send_word(OP_WAIT, 32'h0, 16'h0, 32'h0);
        // long timeout, then a burst of ticks applied by one schedule
        drain_and_config(6'd32);
        send_word(OP_WAIT, 32'h0, 16'hFFFF, 32'h0);
        calm_phase = 1'b1;
        for (int i = 0; i < 5; i++) send_word(OP_TICK, 32'h0, 16'h0, 32'h0);
        send_word(OP_WAIT, 32'h0, 16'h0, 32'h0);
        calm_phase = 1'b0;
        for (int c = 0; c < 8; c++) begin
            drain_and_config(cfg_list[c]);
            if (c == 2) begin
                hold_off = 1'b1;
                for (int i = 0; i < 20; i++) random_word();
            end
            if (c == 5) calm_phase = 1'b1;
            for (int i = 0; i < 65; i++) random_word();
            calm_phase = 1'b0;
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("event_timeout_round_robin_scheduler_core regression: pass");
        else
            $display("event_timeout_round_robin_scheduler_core regression: fail");
        $finish;
    end
endmodule
